// ===== rtl/core/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle stack package
// Types and constants shared by the clip rectangle stack: transaction
// payloads, operation codes, configuration register indexes and states.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned TargetW = 15;
  localparam int unsigned NestW   = 16;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    KindPush  = 2'd0,
    KindPop   = 2'd1,
    KindClear = 2'd2,
    KindNop   = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetWidth  = 1'b0,
    CfgTargetHeight = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    StIdle    = 1'b0,
    StPopRead = 1'b1
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [FieldW-1:0]  rect_left;
    logic [FieldW-1:0]  rect_top;
    logic [FieldW-1:0]  rect_right;
    logic [FieldW-1:0]  rect_bottom;
  } in_t;

  typedef struct packed {
    logic [FieldW-1:0] clip_left;
    logic [FieldW-1:0] clip_top;
    logic [FieldW-1:0] clip_right;
    logic [FieldW-1:0] clip_bottom;
    logic              all_clipped;
    logic              stack_overflow;
  } out_t;

endpackage

// ===== rtl/core/clip_rectangle_stack.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle stack
// Intersects pushed rectangles with the current clip, keeps the non-empty
// results in a stack memory and counts nested nothing-visible pushes.
// The result strobe is registered and follows an accepted start in the next
// cycle; a pop that uncovers an older stacked rectangle first reads it from
// the stack memory in the pop-read state. Throughput: one transaction per
// cycle while not busy; such a pop holds busy during that memory read. The receiver cannot stall the result.
// Reset clears depth, nesting count, target size and the strobe; the stack
// memory is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module clip_rectangle_stack #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  crs_pkg::in_t                in_i,
  output logic                        done_o,
  output crs_pkg::out_t               out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [crs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [crs_pkg::TargetW-1:0] cfg_data_i
);

  localparam int unsigned CW = (COORD_BITS > crs_pkg::FieldW) ? COORD_BITS : crs_pkg::FieldW;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = 4 * CW;

  crs_pkg::state_e state_q, state_d;

  logic [crs_pkg::TargetW-1:0] width_q, height_q;
  logic [DW-1:0]               depth_q, depth_d;
  logic [crs_pkg::NestW-1:0]   nest_q, nest_d;
  logic [EW-1:0]               top_q, top_d;
  logic [EW-1:0]               rdata_q;
  logic [EW-1:0]               mem_q [STACK_DEPTH];

  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic                        done_q, done_d;
  crs_pkg::out_t               out_q, out_d;
  logic                        ovf;

  logic [EW-1:0]               target_rect, cur_rect, new_rect, next_rect;
  logic signed [CW-1:0]        in_l, in_t, in_r, in_b;
  logic signed [CW-1:0]        cur_l, cur_t, cur_r, cur_b;
  logic signed [CW-1:0]        n_l, n_t, n_r, n_b;
  logic signed [COORD_BITS-1:0] raw_l, raw_t, raw_r, raw_b;
  logic                        accept;

  assign accept      = start_i && (state_q == crs_pkg::StIdle);
  assign busy_o      = (state_q != crs_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign out_o       = out_q;

  always_comb begin
    raw_l = COORD_BITS'(in_i.rect_left);
    raw_t = COORD_BITS'(in_i.rect_top);
    raw_r = COORD_BITS'(in_i.rect_right);
    raw_b = COORD_BITS'(in_i.rect_bottom);
    in_l = CW'(raw_l);
    in_t = CW'(raw_t);
    in_r = CW'(raw_r);
    in_b = CW'(raw_b);
  end

  assign target_rect = {CW'(0), CW'(0), CW'(width_q), CW'(height_q)};
  assign cur_rect    = (depth_q != '0) ? top_q : target_rect;

  always_comb begin
    {cur_l, cur_t, cur_r, cur_b} = cur_rect;
    n_l = (cur_l > in_l) ? cur_l : in_l;
    n_t = (cur_t > in_t) ? cur_t : in_t;
    n_r = (cur_r < in_r) ? cur_r : in_r;
    n_b = (cur_b < in_b) ? cur_b : in_b;
    new_rect = {n_l, n_t, n_r, n_b};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crs_pkg::StIdle: begin
        if (accept && (in_i.kind == crs_pkg::KindPop) && (nest_q == '0)
            && (depth_q > DW'(1))) begin
          state_d = crs_pkg::StPopRead;
        end
      end
      crs_pkg::StPopRead: begin
        state_d = crs_pkg::StIdle;
      end
      default: begin
        state_d = crs_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    depth_d = depth_q;
    nest_d  = nest_q;
    top_d   = top_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = depth_q[AW-1:0];
    raddr   = AW'(depth_q - DW'(2));
    ovf     = 1'b0;
    done_d  = 1'b0;
    if (state_q == crs_pkg::StPopRead) begin
      top_d  = rdata_q;
      done_d = 1'b1;
    end else if (accept) begin
      unique case (in_i.kind)
        crs_pkg::KindPush: begin
          if (nest_q != '0) begin
            if (nest_q != '1) begin
              nest_d = nest_q + 1'b1;
            end
          end else if ((n_l < n_r) && (n_t < n_b)) begin
            if (depth_q < DW'(STACK_DEPTH)) begin
              we      = 1'b1;
              top_d   = new_rect;
              depth_d = depth_q + 1'b1;
            end else begin
              ovf = 1'b1;
            end
          end else begin
            nest_d = crs_pkg::NestW'(1);
          end
        end
        crs_pkg::KindPop: begin
          if (nest_q != '0) begin
            nest_d = nest_q - 1'b1;
          end else if (depth_q > DW'(1)) begin
            re      = 1'b1;
            depth_d = depth_q - 1'b1;
          end else if (depth_q == DW'(1)) begin
            depth_d = '0;
          end
        end
        crs_pkg::KindClear: begin
          depth_d = '0;
          nest_d  = '0;
        end
        default: begin
        end
      endcase
      done_d = !re;
    end
    next_rect = (depth_d != '0) ? top_d : target_rect;
    out_d.clip_left      = next_rect[3*CW +: crs_pkg::FieldW];
    out_d.clip_top       = next_rect[2*CW +: crs_pkg::FieldW];
    out_d.clip_right     = next_rect[1*CW +: crs_pkg::FieldW];
    out_d.clip_bottom    = next_rect[0 +: crs_pkg::FieldW];
    out_d.all_clipped    = (nest_d != '0);
    out_d.stack_overflow = ovf;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= new_rect;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (done_d) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= crs_pkg::StIdle;
      depth_q  <= '0;
      nest_q   <= '0;
      done_q   <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      nest_q  <= nest_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          crs_pkg::CfgTargetWidth:  width_q  <= cfg_data_i;
          crs_pkg::CfgTargetHeight: height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule
